// ----- hw/rtl/sue_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the stereo upmix with expander.
// Used by sue_apb_regs, sue_expander and stereo_upmix_with_expander; no dependencies.
package sue_pkg;

    localparam int GAIN_SHIFT  = 30;
    localparam int RATIO_SHIFT = 13;
    localparam int THR_FRAC    = 15;

    localparam logic signed [30:0] GAIN_M6DB = 31'sd538159402;
    localparam logic signed [30:0] GAIN_M3DB = 31'sd760101837;
    localparam logic signed [30:0] GAIN_M2DB = 31'sd852873131;
    localparam logic [30:0]        GAIN_HALF = 31'd536870912;

    localparam logic [15:0] RATIO_ONE  = 16'd8192;
    localparam logic [15:0] RATIO_HALF = 16'd4096;

    localparam logic REG_IDX_RATIO     = 1'b0;
    localparam logic REG_IDX_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [15:0] expand_ratio;
        logic [14:0] expand_threshold;
    } sue_cfg_t;

endpackage

// ----- hw/rtl/sue_apb_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on sue_pkg for the register indexes and the configuration struct.
module sue_apb_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sue_pkg::sue_cfg_t   cfg
);
    import sue_pkg::*;

    logic [15:0] ratio_reg;
    logic [14:0] threshold_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_ONE;
            threshold_reg <= 15'd0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_IDX_RATIO:     ratio_reg     <= pwdata[15:0];
                REG_IDX_THRESHOLD: threshold_reg <= pwdata[14:0];
                default:           ratio_reg     <= ratio_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IDX_RATIO:     prdata = {16'd0, ratio_reg};
            REG_IDX_THRESHOLD: prdata = {17'd0, threshold_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.expand_ratio     = ratio_reg;
    assign cfg.expand_threshold = threshold_reg;

endmodule

// ----- hw/rtl/sue_expander.sv -----
`timescale 1ns / 1ps
// Two-stage hard-knee downward expander for one surround channel.
// Depends on sue_pkg; the stage enables come from the pipeline control in the top level.
module sue_expander #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en_a,
    input  logic                           en_b,
    input  sue_pkg::sue_cfg_t              cfg,
    input  logic signed [SAMPLE_BITS-1:0]  x,
    output logic signed [SAMPLE_BITS-1:0]  e
);
    import sue_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam int PB = F + 16;

    logic [F-1:0]   t;
    logic           bypass;
    logic [15:0]    r;
    logic           neg_next;
    logic [F-1:0]   m_next;
    logic [F-1:0]   d_next;
    logic [PB-1:0]  p_next;

    logic                 neg_reg;
    logic [F-1:0]         m_reg;
    logic                 lt_reg;
    logic                 mz_reg;
    logic [PB-1:0]        p_reg;
    logic signed [SB-1:0] x_reg;
    logic signed [SB-1:0] e_reg;

    logic [PB:0]    p_plus_r;
    logic [PB:0]    x_scaled;
    logic [PB:0]    p_round;
    logic [PB-13:0] rp;
    logic           le;
    logic           knee;
    logic           dead;
    logic [F-1:0]   o;
    logic [SB-1:0]  o_ext;
    logic signed [SB-1:0] e_next;

    generate
        if (F >= THR_FRAC)
        begin : g_thr_up
            assign t = F'(cfg.expand_threshold) << (F - THR_FRAC);
        end
        else
        begin : g_thr_down
            assign t = F'(cfg.expand_threshold >> (THR_FRAC - F));
        end
    endgenerate

    assign r      = cfg.expand_ratio;
    assign bypass = (t == '0) || (r == RATIO_ONE);

    assign neg_next = x[SB-1];
    assign m_next   = neg_next ? F'(-x) : F'(x);
    assign d_next   = t - m_next;
    assign p_next   = PB'(r) * PB'(d_next);

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            neg_reg <= neg_next;
            m_reg   <= m_next;
            lt_reg  <= m_next < t;
            mz_reg  <= m_next == '0;
            p_reg   <= p_next;
            x_reg   <= x;
        end
    end

    // A magnitude equal to the threshold falls in the dead region when the zero point reaches it.
    assign p_plus_r = (PB+1)'(p_reg) + (PB+1)'(r);
    assign x_scaled = (PB+1)'(t) << RATIO_SHIFT;
    assign le       = mz_reg || ((r != '0) && (lt_reg || (m_reg == t)) && (x_scaled < p_plus_r));
    assign knee     = lt_reg && !le;
    assign dead     = !mz_reg && le;
    assign p_round  = (PB+1)'(p_reg) + (PB+1)'(RATIO_HALF);
    assign rp       = p_round[PB:RATIO_SHIFT];

    always_comb
    begin
        if (knee)
            o = ((PB-12)'(t) < (PB-12)'(rp)) ? '0 : F'((PB-12)'(t) - (PB-12)'(rp));
        else if (dead)
            o = '0;
        else
            o = m_reg;
        o_ext = SB'(o);
        if (bypass)
            e_next = x_reg;
        else if (neg_reg)
            e_next = -$signed(o_ext);
        else
            e_next = $signed(o_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            e_reg <= e_next;
    end

    assign e = e_reg;

    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (en_b && !bypass && !neg_reg) |=> !e_reg[SB-1])
        else $error("expander turned a non-negative sample negative");

    a_bypass_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (en_b && bypass) |=> (e_reg == $past(x_reg)))
        else $error("expander altered a sample while bypassed");

    a_dead_region: assert property (@(posedge clk) disable iff (!rst_n)
        (en_a && !bypass && (x == '0)) |=> (m_reg == '0))
        else $error("zero sample did not give zero magnitude");

endmodule

// ----- hw/rtl/stereo_upmix_with_expander.sv -----
`timescale 1ns / 1ps
// Top level of the stereo to five-channel upmix with surround expander.
// Depends on sue_pkg, sue_apb_regs and sue_expander.
//
// Usage: each item on the s_ channel is one stereo pair; each item on the m_
// channel holds the five output channels for that pair, in input order.
// The block has six register stages: gain products, rounding and sum, centre
// product and expander compare, expander output and centre rounding, output
// products, and the saturating output register. One item can be accepted every
// cycle unless a stalled receiver has filled every stage; the rate is set by the
// six-stage pipeline. Each stage takes a new item whenever it is empty or its
// successor moves, so a stalled receiver fills the stages one by one and s_tready
// falls only when all six hold an item. Nothing is dropped or repeated while
// stalled.
// Reset clears all valid bits and sets the expander to bypass (ratio 1.0,
// threshold 0). The expander registers may be written over the APB port only
// while no item is in flight.
module stereo_upmix_with_expander #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_left_surround, out_left, out_center, out_right, out_right_surround
    output logic [((5*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import sue_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = SAMPLE_BITS + 31;
    localparam int PW1 = SAMPLE_BITS + 32;
    localparam int OW  = ((5*SAMPLE_BITS+7)/8)*8;
    localparam int NST = 6;

    sue_cfg_t cfg;

    logic [NST:1] v_reg;
    logic [NST:1] v_next;
    logic [NST:1] en;

    logic signed [SB-1:0]  sl;
    logic signed [SB-1:0]  sr;

    logic signed [PW-1:0]  pl_reg;
    logic signed [PW-1:0]  pr_reg;
    logic signed [PW-1:0]  pl_half;
    logic signed [PW-1:0]  pr_half;
    logic signed [SB-1:0]  lg_next;
    logic signed [SB-1:0]  rg_next;
    logic signed [SB-1:0]  lg_reg;
    logic signed [SB-1:0]  rg_reg;
    logic signed [SB:0]    sum_reg;

    logic signed [PW1-1:0] pc_reg;
    logic signed [PW1-1:0] pc_half;
    logic signed [SB:0]    c4_reg;

    logic signed [SB-1:0]  el;
    logic signed [SB-1:0]  er;

    logic signed [PW1-1:0] pf_reg;
    logic signed [PW-1:0]  psl_reg;
    logic signed [PW-1:0]  psr_reg;
    logic signed [SB:0]    c5_reg;

    logic signed [PW1-1:0] pf_half;
    logic signed [PW-1:0]  psl_half;
    logic signed [PW-1:0]  psr_half;
    logic signed [SB+1:0]  front_w;
    logic signed [SB+1:0]  ls_w;
    logic signed [SB+1:0]  rs_w;

    logic [SB-1:0] ls_reg;
    logic [SB-1:0] front_reg;
    logic [SB-1:0] c_reg;
    logic [SB-1:0] rs_reg;

    function automatic logic [SB-1:0] sat(input logic signed [SB+1:0] v);
        logic signed [SB+1:0] hi;
        logic signed [SB+1:0] lo;
        hi = {3'b000, {(SB-1){1'b1}}};
        lo = {3'b111, {(SB-1){1'b0}}};
        if (v > hi)
            sat = hi[SB-1:0];
        else if (v < lo)
            sat = lo[SB-1:0];
        else
            sat = v[SB-1:0];
    endfunction

    sue_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        en[NST] = !v_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[1] = s_tvalid;
        for (int k = 2; k <= NST; k++)
            v_next[k] = v_reg[k-1];
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 1; k <= NST; k++)
                if (en[k])
                    v_reg[k] <= v_next[k];
        end
    end

    assign sl = s_tdata[SB-1:0];
    assign sr = s_tdata[2*SB-1:SB];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pl_reg <= PW'(sl) * PW'(GAIN_M6DB);
            pr_reg <= PW'(sr) * PW'(GAIN_M6DB);
        end
    end

    assign pl_half = pl_reg + $signed(PW'(GAIN_HALF));
    assign pr_half = pr_reg + $signed(PW'(GAIN_HALF));
    assign lg_next = pl_half[SB+GAIN_SHIFT-1:GAIN_SHIFT];
    assign rg_next = pr_half[SB+GAIN_SHIFT-1:GAIN_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            lg_reg  <= lg_next;
            rg_reg  <= rg_next;
            sum_reg <= (SB+1)'(lg_next) + (SB+1)'(rg_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            pc_reg <= PW1'(sum_reg) * PW1'(GAIN_M3DB);
    end

    assign pc_half = pc_reg + $signed(PW1'(GAIN_HALF));

    always_ff @(posedge clk)
    begin
        if (en[4])
            c4_reg <= pc_half[SB+GAIN_SHIFT:GAIN_SHIFT];
    end

    sue_expander #(.SAMPLE_BITS(SAMPLE_BITS)) u_exp_left (
        .clk   (clk),
        .rst_n (rst_n),
        .en_a  (en[3]),
        .en_b  (en[4]),
        .cfg   (cfg),
        .x     (lg_reg),
        .e     (el)
    );

    sue_expander #(.SAMPLE_BITS(SAMPLE_BITS)) u_exp_right (
        .clk   (clk),
        .rst_n (rst_n),
        .en_a  (en[3]),
        .en_b  (en[4]),
        .cfg   (cfg),
        .x     (rg_reg),
        .e     (er)
    );

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            pf_reg  <= PW1'(c4_reg) * PW1'(GAIN_M6DB);
            psl_reg <= PW'(el) * PW'(GAIN_M2DB);
            psr_reg <= PW'(er) * PW'(GAIN_M2DB);
            c5_reg  <= c4_reg;
        end
    end

    assign pf_half  = pf_reg + $signed(PW1'(GAIN_HALF));
    assign psl_half = psl_reg + $signed(PW'(GAIN_HALF));
    assign psr_half = psr_reg + $signed(PW'(GAIN_HALF));
    assign front_w  = (SB+2)'($signed(pf_half[SB+GAIN_SHIFT:GAIN_SHIFT]));
    assign ls_w     = front_w + (SB+2)'($signed(psl_half[SB+GAIN_SHIFT-1:GAIN_SHIFT]));
    assign rs_w     = front_w + (SB+2)'($signed(psr_half[SB+GAIN_SHIFT-1:GAIN_SHIFT]));

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            ls_reg    <= sat(ls_w);
            front_reg <= sat(front_w);
            c_reg     <= sat((SB+2)'(c5_reg));
            rs_reg    <= sat(rs_w);
        end
    end

    assign m_tdata = OW'({rs_reg, front_reg, c_reg, front_reg, ls_reg});

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> ((v_reg == '1) && !m_tready))
        else $error("input refused while the pipeline had room");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[1])
        else $error("accepted item did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[1] && !en[2]) |=> (v_reg[1] && $stable(pl_reg) && $stable(pr_reg)))
        else $error("first stage changed while its successor was stalled");

    a_fronts_equal: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST] |-> (m_tdata[2*SB-1:SB] == m_tdata[4*SB-1:3*SB]))
        else $error("front channels differ");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stereo_upmix_with_expander: stereo pairs in, five channels out.
// A scoreboard class predicts every output item; depends on sue_pkg and the block's RTL.
module tb_top;
    import sue_pkg::*;

    localparam int     SB          = 16;
    localparam int     FRAC        = SB - 1;
    localparam int     S_W         = ((2 * SB + 7) / 8) * 8;
    localparam int     M_W         = ((5 * SB + 7) / 8) * 8;
    localparam longint UNITY       = RATIO_ONE;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     NUM_PHASES  = 10;
    localparam int     PHASE_ITEMS = 185;
    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

    typedef struct packed {
        logic [SB-1:0] surround_right;
        logic [SB-1:0] front_right;
        logic [SB-1:0] centre;
        logic [SB-1:0] front_left;
        logic [SB-1:0] surround_left;
    } channels_t;

    class upmix_scoreboard;
        longint    ratio;
        longint    threshold;
        channels_t expected_channels[$];
        int        errors;
        int        checked;
        int        noted;

        function new();
            ratio     = UNITY;
            threshold = 0;
            errors    = 0;
            checked   = 0;
            noted     = 0;
        endfunction

        function void set_config(logic [15:0] r, logic [14:0] t);
            ratio     = r;
            threshold = t;
        endfunction

        function longint round_floor(longint p, int s);
            return (p + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint apply_gain(longint x, longint g);
            return round_floor(x * g, GAIN_SHIFT);
        endfunction

        function longint clamp(longint v);
            if (v > longint'($signed(S_MAX)))
            begin
                return longint'($signed(S_MAX));
            end
            if (v < longint'($signed(S_MIN)))
            begin
                return longint'($signed(S_MIN));
            end
            return v;
        endfunction

        function longint expand(longint x);
            longint t;
            longint z;
            longint m;
            longint o;
            bit     neg;
            if (FRAC >= THR_FRAC)
            begin
                t = threshold << (FRAC - THR_FRAC);
            end
            else
            begin
                t = threshold >> (THR_FRAC - FRAC);
            end
            if (t == 0 || ratio == UNITY)
            begin
                return x;
            end
            z = (ratio != 0) ? t - (t * UNITY) / ratio : 0;
            if (z < 0)
            begin
                z = 0;
            end
            neg = x < 0;
            m   = neg ? -x : x;
            if (m > z && m < t)
            begin
                o = t - round_floor(ratio * (t - m), RATIO_SHIFT);
                if (o < 0)
                begin
                    o = 0;
                end
            end
            else if (m > 0 && m <= z)
            begin
                o = 0;
            end
            else
            begin
                o = m;
            end
            return neg ? -o : o;
        endfunction

        function channels_t predict_channels(logic [SB-1:0] l, logic [SB-1:0] r);
            longint    lg;
            longint    rg;
            longint    c;
            longint    front;
            channels_t ch;
            lg    = apply_gain(longint'($signed(l)), GAIN_M6DB);
            rg    = apply_gain(longint'($signed(r)), GAIN_M6DB);
            c     = apply_gain(lg + rg, GAIN_M3DB);
            front = apply_gain(c, GAIN_M6DB);
            ch.surround_left  = SB'(clamp(apply_gain(expand(lg), GAIN_M2DB) + front));
            ch.front_left     = SB'(clamp(front));
            ch.centre         = SB'(clamp(c));
            ch.front_right    = SB'(clamp(front));
            ch.surround_right = SB'(clamp(apply_gain(expand(rg), GAIN_M2DB) + front));
            return ch;
        endfunction

        function int pending();
            return expected_channels.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task note_pair(logic [2*SB-1:0] data);
            expected_channels.push_back(predict_channels(data[SB-1:0], data[2*SB-1:SB]));
            noted++;
        endtask

        task compare_field(string name, logic [SB-1:0] got, logic [SB-1:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %0d, expected %0d", name, $signed(got),
                                 $signed(want)));
            end
        endtask

        task check_channels(channels_t got);
            channels_t want;
            if (expected_channels.size() == 0)
            begin
                report("output item arrived with nothing expected");
                return;
            end
            want = expected_channels.pop_front();
            checked++;
            compare_field("out_left_surround", got.surround_left, want.surround_left);
            compare_field("out_left", got.front_left, want.front_left);
            compare_field("out_center", got.centre, want.centre);
            compare_field("out_right", got.front_right, want.front_right);
            compare_field("out_right_surround", got.surround_right, want.surround_right);
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [M_W-1:0]  m_tdata;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    upmix_scoreboard sb = new();
    bit              quiet;
    int              settings;
    longint          cycle_count;

    logic [15:0] phase_ratio [NUM_PHASES] = '{16'd8192, 16'd65535, 16'd0, 16'd16384,
                                               16'd4096, 16'd1, 16'd24576, 16'd40000,
                                               16'd0, 16'd0};
    logic [14:0] phase_thr   [NUM_PHASES] = '{15'd12000, 15'd32767, 15'd32767, 15'd8000,
                                               15'd16000, 15'd300, 15'd0, 15'd1,
                                               15'd0, 15'd0};

    stereo_upmix_with_expander #(
        .SAMPLE_BITS(SB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_pair(s_tdata[2*SB-1:0]);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_channels(channels_t'(m_tdata[5*SB-1:0]));
            end
        end
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 65)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SB-1:0] rand_sample(logic [14:0] thr);
        int pick;
        int span;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return SB'($urandom);
        end
        if (pick == 8)
        begin
            case ($urandom_range(0, 4))
                0: return S_MAX;
                1: return S_MIN;
                2: return '0;
                3: return SB'(1);
                default: return '1;
            endcase
        end
        if (pick == 9)
        begin
            mag = $urandom_range(0, 15);
        end
        else
        begin
            // The left and right gains halve the input, so the knee sits near twice the threshold.
            span = 2 * thr + 64;
            if (span > 32768)
            begin
                span = 32768;
            end
            mag = $urandom_range(0, span);
        end
        if ($urandom_range(0, 1))
        begin
            return SB'(-mag);
        end
        if (mag > 32767)
        begin
            mag = 32767;
        end
        return SB'(mag);
    endfunction

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic send_pair(logic [SB-1:0] l, logic [SB-1:0] r);
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({r, l});
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [15:0] r, logic [14:0] t);
        wait_drained();
        write_reg(REG_IDX_RATIO, {16'($urandom), r});
        write_reg(REG_IDX_THRESHOLD, {17'($urandom), t});
        sb.set_config(r, t);
        settings++;
    endtask

    task automatic send_random_pairs(int count, logic [14:0] thr, bit hold_mid);
        for (int i = 0; i < count; i++)
        begin
            if (hold_mid && i == count / 2)
            begin
                wait_drained();
            end
            send_pair(rand_sample(thr), rand_sample(thr));
            idle_gap(gap_len());
        end
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d items outstanding.", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [15:0] r;
        logic [14:0] t;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        settings = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings leave the expander in bypass; full-scale and tiny inputs.
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair('0, '0);
        send_pair(SB'(1), '1);

        // Ratio 2.0 and threshold 8000 put the zero point at 4000 after the gain.
        configure(16'd16384, 15'd8000);
        send_pair('0, SB'(3990));
        send_pair(SB'(7980), SB'(-7980));
        send_pair(SB'(7982), SB'(-7982));
        send_pair(SB'(12000), SB'(-15959));
        send_pair(SB'(15962), SB'(-15962));
        send_pair(SB'(20000), '1);

        // A zero ratio has no dead region and lifts the whole knee to the threshold.
        configure(16'd0, 15'd20000);
        send_pair(SB'(30000), SB'(-30000));
        send_pair(SB'(2), SB'(-25000));
        send_pair(S_MIN, S_MAX);

        configure(16'd1, 15'd300);
        send_pair(SB'(500), SB'(-598));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            r = (p >= 8) ? 16'($urandom) : phase_ratio[p];
            t = (p >= 8) ? 15'($urandom) : phase_thr[p];
            configure(r, t);
            quiet = (p % 3 == 1);
            send_random_pairs(PHASE_ITEMS, t, p == 3);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (12) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d expected items never arrived", sb.pending()));
        end

        $display("Sent %0d stereo pairs under %0d expander settings, bypass and extremes included.",
                 sb.noted, settings);
        $display("Checked %0d five-channel items with %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
